FILE: hw/rtl/pcd_pkg.sv
// Shared constants, transaction types and control bundles of the path conflict detector.
`timescale 1ns / 1ps
package pcd_pkg;

    localparam int MAX_AGENTS = 16;
    localparam int MAX_STEPS  = 256;
    localparam int COORD_BITS = 8;

    localparam int AGENT_W = $clog2(MAX_AGENTS);
    localparam int CNT_W   = AGENT_W + 1;
    localparam int STEP_W  = $clog2(MAX_STEPS);
    localparam int LEN_W   = STEP_W + 1;
    localparam int CELL_W  = 2 * COORD_BITS;
    localparam int ADDR_W  = AGENT_W + STEP_W;
    localparam int CFG_W   = 5;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_EDGE   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] agent;
        logic [7:0] step;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       last;
    } req_item_t;

    typedef struct packed {
        logic        found;
        logic        kind;
        logic [7:0]  conflict_time;
        logic [7:0]  node_x;
        logic [7:0]  node_y;
        logic [7:0]  to_x;
        logic [7:0]  to_y;
        logic [15:0] agent_mask;
        logic [3:0]  first_agent;
        logic [3:0]  second_agent;
    } rsp_item_t;

    typedef struct packed {
        logic               valid;
        logic [AGENT_W-1:0] agent;
        logic [STEP_W-1:0]  step;
        logic               last;
    } load_ctl_t;

    typedef struct packed {
        logic valid;
        logic is_edge;
    } search_ctl_t;

endpackage

FILE: hw/rtl/path_conflict_detector.sv
// Top level of the path conflict detector: handshakes, agent count register, result register.
`timescale 1ns / 1ps
// Stores one grid path per agent in a 4096 x 16 cell RAM and searches it for the
// earliest vertex conflict (two agents on one cell) or edge conflict (two agents
// swapping cells). A path cell load is written straight into the RAM and the next
// transaction may follow in the next cycle. A search walks time steps t = 0, 1, ...
// up to the longest active path or the first conflict; each step passes a setup
// state, then reads one cell per agent slot (n = agent_count capped at 16, empty
// paths included) through the single RAM read port and drains the read pipeline.
// Agents past their final cell wait on it. Program agent_count only while idle;
// loads are held off while a search runs, and a finished report waits in the
// output register without blocking further loads.
module path_conflict_detector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  pcd_pkg::req_item_t             req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output pcd_pkg::rsp_item_t             rsp_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = pcd_pkg::AGENT_W;
    localparam int SW = pcd_pkg::STEP_W;
    localparam int BW = pcd_pkg::COORD_BITS;

    logic [pcd_pkg::CFG_W-1:0] agent_count_reg;
    logic                      rsp_valid_reg;
    pcd_pkg::rsp_item_t        rsp_data_reg;

    logic                         accept;
    logic                         busy, done, out_free;
    pcd_pkg::load_ctl_t           load;
    pcd_pkg::search_ctl_t         cmd;
    pcd_pkg::rsp_item_t           result;
    logic                         rd_en;
    logic [pcd_pkg::ADDR_W-1:0]   rd_addr;
    logic [pcd_pkg::CELL_W-1:0]   rd_data;

    // hold off new transactions while a search walks the RAM
    assign req_stall = busy;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign load.valid = accept && (req_data.op == pcd_pkg::OP_LOAD);
    assign load.agent = AW'(req_data.agent);
    assign load.step  = SW'(req_data.step);
    assign load.last  = req_data.last;

    assign cmd.valid   = accept && ((req_data.op == pcd_pkg::OP_VERTEX) ||
                                    (req_data.op == pcd_pkg::OP_EDGE));
    assign cmd.is_edge = (req_data.op == pcd_pkg::OP_EDGE);

    // the result register is free when empty or draining this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    pcd_ram #(
        .ADDR_BITS (pcd_pkg::ADDR_W),
        .WIDTH     (pcd_pkg::CELL_W)
    ) u_cells (
        .clk   (clk),
        .we    (load.valid),
        .waddr ({load.agent, load.step}),
        .wdata ({BW'(req_data.cell_y), BW'(req_data.cell_x)}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pcd_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .cmd         (cmd),
        .agent_count (agent_count_reg),
        .out_free    (out_free),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agent_count_reg <= pcd_pkg::CFG_W'(1);
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                agent_count_reg <= cfg_data;
            end
            // load a finished report, drop a taken one
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

FILE: hw/rtl/pcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pcd_ram #(
    parameter int ADDR_BITS = 12,
    parameter int WIDTH     = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/pcd_engine.sv
// Search engine: path lengths, per-time-step scan of the cell RAM and conflict capture.
`timescale 1ns / 1ps
module pcd_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcd_pkg::load_ctl_t                  load,
    input  pcd_pkg::search_ctl_t                cmd,
    input  logic [pcd_pkg::CFG_W-1:0]           agent_count,
    input  logic                                out_free,
    output logic                                rd_en,
    output logic [pcd_pkg::ADDR_W-1:0]          rd_addr,
    input  logic [pcd_pkg::CELL_W-1:0]          rd_data,
    output logic                                busy,
    output logic                                done,
    output pcd_pkg::rsp_item_t                  result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_MASK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam int NA = pcd_pkg::MAX_AGENTS;
    localparam int AW = pcd_pkg::AGENT_W;
    localparam int CW = pcd_pkg::CNT_W;
    localparam int LW = pcd_pkg::LEN_W;
    localparam int SW = pcd_pkg::STEP_W;
    localparam int XW = pcd_pkg::CELL_W;
    localparam int BW = pcd_pkg::COORD_BITS;

    logic [2:0]    state_reg, state_next;
    logic          edge_reg;
    logic [CW-1:0] n_reg;
    logic [LW-1:0] t_reg;
    logic [CW-1:0] ia_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_agent_reg;
    logic          hit_reg;
    logic [XW-1:0] hit_cell_reg;
    logic [XW-1:0] to_reg;
    logic [AW-1:0] first_reg;
    logic [AW-1:0] second_reg;
    logic [NA-1:0] mask_reg;
    logic [LW-1:0] len_reg  [NA];
    logic [XW-1:0] cur_reg  [NA];
    logic [XW-1:0] prev_reg [NA];

    logic [NA-1:0] vpart, epart, vmatch, ematch, mask_calc;
    logic [CW-1:0] n_sat;
    logic          alive, issue, pass_end;
    logic [AW-1:0] ia_idx, sec_idx;
    logic [LW-1:0] len_sel, step_sel;
    logic [XW-1:0] from_j;
    logic          vhit, ehit, hit_now;

    assign n_sat = (agent_count > pcd_pkg::CFG_W'(NA)) ? CW'(NA) : CW'(agent_count);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            vpart[i] = (CW'(i) < n_reg) && (len_reg[i] != '0);
            epart[i] = (CW'(i) < n_reg) && (len_reg[i] > t_reg);
        end
    end

    assign alive = |epart;

    // read issue: one agent per cycle, address clamped to the final cell
    assign ia_idx   = ia_reg[AW-1:0];
    assign issue    = (state_reg == ST_SCAN) && (ia_reg < n_reg);
    assign len_sel  = len_reg[ia_idx];
    assign step_sel = (t_reg < len_sel) ? t_reg : (len_sel - LW'(1));
    assign rd_en    = issue;
    assign rd_addr  = {ia_idx, step_sel[SW-1:0]};
    assign pass_end = (state_reg == ST_SCAN) && !issue && !pend_reg;

    assign from_j = prev_reg[pend_agent_reg];

    always_comb
    begin
        sec_idx = '0;
        for (int i = 0; i < NA; i++)
        begin
            vmatch[i] = (AW'(i) < pend_agent_reg) && vpart[i] && (cur_reg[i] == rd_data);
            ematch[i] = (AW'(i) < pend_agent_reg) && epart[i] &&
                        (prev_reg[i] == rd_data) && (cur_reg[i] == from_j);
            mask_calc[i] = vpart[i] && (cur_reg[i] == hit_cell_reg);
            if (ematch[i])
            begin
                sec_idx = AW'(i);
            end
        end
    end

    assign vhit    = vpart[pend_agent_reg] && (|vmatch);
    assign ehit    = (t_reg != '0) && epart[pend_agent_reg] && (from_j != rd_data) && (|ematch);
    assign hit_now = pend_reg && !hit_reg && (edge_reg ? ehit : vhit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = alive ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (pass_end)
                begin
                    if (hit_reg)
                    begin
                        state_next = edge_reg ? ST_FINISH : ST_MASK;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_MASK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            for (int i = 0; i < NA; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (state_reg == ST_IDLE && cmd.valid)
            begin
                hit_reg <= 1'b0;
            end
            else if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (load.valid)
            begin
                if (load.last)
                begin
                    len_reg[load.agent] <= LW'(load.step) + LW'(1);
                end
                else if (load.step == '0)
                begin
                    len_reg[load.agent] <= '0;
                end
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd.valid)
        begin
            edge_reg <= cmd.is_edge;
            n_reg    <= n_sat;
            t_reg    <= '0;
        end
        if (state_reg == ST_START)
        begin
            ia_reg <= '0;
        end
        else if (issue)
        begin
            ia_reg <= ia_reg + CW'(1);
        end
        pend_agent_reg <= ia_idx;
        if (pend_reg)
        begin
            cur_reg[pend_agent_reg] <= rd_data;
        end
        if (hit_now)
        begin
            hit_cell_reg <= edge_reg ? from_j : rd_data;
            to_reg       <= rd_data;
            first_reg    <= pend_agent_reg;
            second_reg   <= sec_idx;
        end
        if (pass_end && !hit_reg)
        begin
            t_reg <= t_reg + LW'(1);
            for (int i = 0; i < NA; i++)
            begin
                prev_reg[i] <= cur_reg[i];
            end
        end
        if (state_reg == ST_MASK)
        begin
            mask_reg <= mask_calc;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        result      = '0;
        result.kind = edge_reg ? pcd_pkg::KIND_EDGE : pcd_pkg::KIND_VERTEX;
        if (hit_reg)
        begin
            result.found         = 1'b1;
            result.conflict_time = t_reg[7:0];
            result.node_x        = 8'(hit_cell_reg[BW-1:0]);
            result.node_y        = 8'(hit_cell_reg[XW-1:BW]);
            if (edge_reg)
            begin
                result.to_x         = 8'(to_reg[BW-1:0]);
                result.to_y         = 8'(to_reg[XW-1:BW]);
                result.first_agent  = 4'(first_reg);
                result.second_agent = 4'(second_reg);
            end
            else
            begin
                result.agent_mask = 16'(mask_reg);
            end
        end
    end

endmodule

FILE: hw/rtl/pcd_checker.sv
// Port-level checker for the path conflict detector and its bind.
`timescale 1ns / 1ps
module pcd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input pcd_pkg::rsp_item_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled report changed");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |-> rsp_data.conflict_time == '0 &&
        rsp_data.agent_mask == '0 && rsp_data.first_agent == '0 &&
        rsp_data.node_x == '0 && rsp_data.to_y == '0)
        else $error("empty report carries data");

    a_vertex_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.found && rsp_data.kind == pcd_pkg::KIND_VERTEX |->
        $countones(rsp_data.agent_mask) >= 2 && rsp_data.first_agent == '0)
        else $error("vertex report needs two agents");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.found && rsp_data.kind == pcd_pkg::KIND_EDGE |->
        rsp_data.first_agent > rsp_data.second_agent &&
        rsp_data.conflict_time != '0 && rsp_data.agent_mask == '0)
        else $error("edge report malformed");

endmodule

bind path_conflict_detector pcd_checker u_pcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
